// ===== hdl/hsv_to_rgb_converter_assert.svh =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter assertion macros
// Shared concurrent assertion forms for the converter's checker.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Consequent must hold in the same cycle; off while reset is asserted.
`define HSV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_converter: assertion failed");

// Consequent must hold in the next cycle; off while reset is asserted.
`define HSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter: assertion failed");

// Consequent must hold in the next cycle; always armed, also during reset.
`define HSV_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter: assertion failed");

`endif

// ===== hdl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and constants shared by the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_out_t;

  // Sextant of the hue circle, from (6*hue) >> 8.
  typedef enum logic [2:0] {
    SECT_RED_YELLOW     = 3'd0,
    SECT_YELLOW_GREEN   = 3'd1,
    SECT_GREEN_CYAN     = 3'd2,
    SECT_CYAN_BLUE      = 3'd3,
    SECT_BLUE_MAGENTA   = 3'd4,
    SECT_MAGENTA_RED    = 3'd5
  } sector_t;

  // Hues that give an exact color at full saturation.
  localparam logic [7:0] HUE_RED_LO  = 8'd0;
  localparam logic [7:0] HUE_YELLOW  = 8'd43;
  localparam logic [7:0] HUE_GREEN   = 8'd85;
  localparam logic [7:0] HUE_CYAN    = 8'd128;
  localparam logic [7:0] HUE_BLUE    = 8'd171;
  localparam logic [7:0] HUE_MAGENTA = 8'd213;
  localparam logic [7:0] HUE_RED_HI  = 8'd255;

  localparam logic [7:0]  CHAN_MAX = 8'd255;
  localparam logic [15:0] FULL16   = 16'd65535;

  // Channel enable masks for exact colors, ordered red, green, blue.
  localparam logic [2:0] MASK_NONE    = 3'b000;
  localparam logic [2:0] MASK_RED     = 3'b100;
  localparam logic [2:0] MASK_YELLOW  = 3'b110;
  localparam logic [2:0] MASK_GREEN   = 3'b010;
  localparam logic [2:0] MASK_CYAN    = 3'b011;
  localparam logic [2:0] MASK_BLUE    = 3'b001;
  localparam logic [2:0] MASK_MAGENTA = 3'b101;
  localparam logic [2:0] MASK_GREY    = 3'b111;

  // Result of the decode stage.
  typedef struct packed {
    logic       exact;
    logic [2:0] mask;
    sector_t    sector;
    logic [7:0] val;
    logic [15:0] xp;
    logic [15:0] xq;
    logic [15:0] xt;
  } stage1_t;

  // Result of the multiply stage: p, q and t already scaled to 8 bits.
  typedef struct packed {
    logic       exact;
    logic [2:0] mask;
    sector_t    sector;
    logic [7:0] val;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } stage2_t;

endpackage

// ===== hdl/hsv2rgb_decode.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_decode
// First stage: sector, fraction, exact-color decode and the three 16-bit
// multiplicands of p, q and t.
// ----------------------------------------------------------------------------
module hsv2rgb_decode
  import hsv2rgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_in,
  input  pixel_in_t data_in,
  output logic      ready_out,
  input  logic      ready_in,
  output logic      valid_out,
  output stage1_t   data_out
);

  logic        valid_r;
  stage1_t     data_r;
  stage1_t     data_nxt;
  logic [10:0] h6;
  logic [7:0]  frac;
  logic [15:0] frac_sat;
  logic [15:0] rfrac_sat;

  assign ready_out = !valid_r || ready_in;
  assign valid_out = valid_r;
  assign data_out  = data_r;

  always_comb begin
    h6        = {1'b0, data_in.hue, 2'b00} + {2'b00, data_in.hue, 1'b0};
    frac      = h6[7:0];
    frac_sat  = 16'(frac) * 16'(data_in.saturation);
    rfrac_sat = 16'(CHAN_MAX - frac) * 16'(data_in.saturation);

    data_nxt.sector = sector_t'(h6[10:8]);
    data_nxt.val    = data_in.brightness;
    data_nxt.xp     = FULL16 - {data_in.saturation, 8'h00};
    data_nxt.xq     = FULL16 - frac_sat;
    data_nxt.xt     = FULL16 - rfrac_sat;

    // Exact colors at full saturation take precedence; grey is the
    // all-channels mask.
    data_nxt.exact = 1'b1;
    data_nxt.mask  = MASK_NONE;
    priority if (data_in.saturation == CHAN_MAX &&
                 (data_in.hue == HUE_RED_LO || data_in.hue == HUE_RED_HI)) begin
      data_nxt.mask = MASK_RED;
    end else if (data_in.saturation == CHAN_MAX && data_in.hue == HUE_YELLOW) begin
      data_nxt.mask = MASK_YELLOW;
    end else if (data_in.saturation == CHAN_MAX && data_in.hue == HUE_GREEN) begin
      data_nxt.mask = MASK_GREEN;
    end else if (data_in.saturation == CHAN_MAX && data_in.hue == HUE_CYAN) begin
      data_nxt.mask = MASK_CYAN;
    end else if (data_in.saturation == CHAN_MAX && data_in.hue == HUE_BLUE) begin
      data_nxt.mask = MASK_BLUE;
    end else if (data_in.saturation == CHAN_MAX && data_in.hue == HUE_MAGENTA) begin
      data_nxt.mask = MASK_MAGENTA;
    end else if (data_in.saturation == 8'd0) begin
      data_nxt.mask = MASK_GREY;
    end else begin
      data_nxt.exact = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_out) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/hsv2rgb_mult.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_mult
// Second stage: three 8 by 16 products of value with the p, q and t
// multiplicands, kept as their top eight bits.
// ----------------------------------------------------------------------------
module hsv2rgb_mult
  import hsv2rgb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    valid_in,
  input  stage1_t data_in,
  output logic    ready_out,
  input  logic    ready_in,
  output logic    valid_out,
  output stage2_t data_out
);

  logic        valid_r;
  stage2_t     data_r;
  stage2_t     data_nxt;
  logic [23:0] prod_p;
  logic [23:0] prod_q;
  logic [23:0] prod_t;

  assign ready_out = !valid_r || ready_in;
  assign valid_out = valid_r;
  assign data_out  = data_r;

  // (val*256 * x) >> 24 equals (val * x) >> 16; the result never exceeds 254.
  always_comb begin
    prod_p = 24'(data_in.val) * 24'(data_in.xp);
    prod_q = 24'(data_in.val) * 24'(data_in.xq);
    prod_t = 24'(data_in.val) * 24'(data_in.xt);

    data_nxt.exact  = data_in.exact;
    data_nxt.mask   = data_in.mask;
    data_nxt.sector = data_in.sector;
    data_nxt.val    = data_in.val;
    data_nxt.p      = prod_p[23:16];
    data_nxt.q      = prod_q[23:16];
    data_nxt.t      = prod_t[23:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_out) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/hsv2rgb_select.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_select
// Third stage: per-sector channel selection or exact color, into the
// output register.
// ----------------------------------------------------------------------------
module hsv2rgb_select
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_in,
  input  stage2_t    data_in,
  output logic       ready_out,
  input  logic       ready_in,
  output logic       valid_out,
  output pixel_out_t data_out
);

  logic       valid_r;
  pixel_out_t data_r;
  pixel_out_t data_nxt;

  assign ready_out = !valid_r || ready_in;
  assign valid_out = valid_r;
  assign data_out  = data_r;

  always_comb begin
    if (data_in.exact) begin
      data_nxt.red   = data_in.mask[2] ? data_in.val : 8'd0;
      data_nxt.green = data_in.mask[1] ? data_in.val : 8'd0;
      data_nxt.blue  = data_in.mask[0] ? data_in.val : 8'd0;
    end else begin
      unique case (data_in.sector)
        SECT_RED_YELLOW: begin
          data_nxt = '{red: data_in.val, green: data_in.t, blue: data_in.p};
        end
        SECT_YELLOW_GREEN: begin
          data_nxt = '{red: data_in.q, green: data_in.val, blue: data_in.p};
        end
        SECT_GREEN_CYAN: begin
          data_nxt = '{red: data_in.p, green: data_in.val, blue: data_in.t};
        end
        SECT_CYAN_BLUE: begin
          data_nxt = '{red: data_in.p, green: data_in.q, blue: data_in.val};
        end
        SECT_BLUE_MAGENTA: begin
          data_nxt = '{red: data_in.t, green: data_in.p, blue: data_in.val};
        end
        default: begin
          data_nxt = '{red: data_in.val, green: data_in.p, blue: data_in.q};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_out) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Three-stage pipelined conversion of 8-bit HSV pixels to 8-bit RGB.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                          Direction  Moves
//   -------  -----------------------------  ---------  -------------------
//   input    in_valid, in_stall, in_pixel   into       one HSV request
//   result   out_valid, out_stall, out_pixel out of    one RGB request
//
// An accepted request moves through the decode, multiply and select
// registers to out_valid; one request enters every cycle unless in_stall.
// The rate is set by the pipeline registers, one request per stage.
// Reset (rst_n low at a clock edge) empties all three stages.
// A stall on the result side holds the output register; the stages behind
// it keep filling bubbles, and in_stall rises only once every stage is full.
//
// Stage one decodes the sector, fraction and the exact-color cases, and
// forms the 16-bit multiplicands of p, q and t with two 8 by 8 products.
// Stage two forms the three 8 by 16 products with the value. Stage three
// picks the channels by sector and loads the output register.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pixel_in_t  in_pixel,
  output logic       out_valid,
  input  logic       out_stall,
  output pixel_out_t out_pixel
);

  logic    s1_ready;
  logic    s1_valid;
  stage1_t s1_data;
  logic    s2_ready;
  logic    s2_valid;
  stage2_t s2_data;
  logic    s3_ready;

  // Each stage is ready when it is empty or when the stage after it moves.
  assign in_stall = !s1_ready;

  hsv2rgb_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (in_valid),
    .data_in   (in_pixel),
    .ready_out (s1_ready),
    .ready_in  (s2_ready),
    .valid_out (s1_valid),
    .data_out  (s1_data)
  );

  hsv2rgb_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (s1_valid),
    .data_in   (s1_data),
    .ready_out (s2_ready),
    .ready_in  (s3_ready),
    .valid_out (s2_valid),
    .data_out  (s2_data)
  );

  hsv2rgb_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (s2_valid),
    .data_in   (s2_data),
    .ready_out (s3_ready),
    .ready_in  (!out_stall),
    .valid_out (out_valid),
    .data_out  (out_pixel)
  );

endmodule

// ===== hdl/hsv2rgb_checker.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks of the converter's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input pixel_in_t  in_pixel,
  input logic       out_valid,
  input logic       out_stall,
  input pixel_out_t out_pixel
);

  `HSV_ASSERT_NEXT(a_in_request_holds, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_pixel))
  `HSV_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_valid && out_stall, out_valid)
  `HSV_ASSERT_NEXT(a_out_pixel_holds, clk, rst_n, out_valid && out_stall, $stable(out_pixel))
  `HSV_ASSERT_NEXT_ALWAYS(a_reset_empties, clk, !rst_n, !out_valid)
  `HSV_ASSERT_NOW(a_drain_no_stall, clk, rst_n, !out_valid || !out_stall, !in_stall)

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_pixel  (in_pixel),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_pixel (out_pixel)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: HSV to RGB converter testbench
// Streams HSV pixels through the pipelined converter under random input
// bursts and output stalls, and checks every RGB result against a predictor
// held in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import hsv2rgb_pkg::*;

  // Which branch of the conversion a pixel takes, kept only for the summary.
  typedef enum logic [1:0] {
    PATH_EXACT,
    PATH_GREY,
    PATH_SEXTANT
  } color_path_t;

  // Output stall patterns that the receiver cycles through.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  localparam int RANDOM_PIXELS   = 650;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_LIMIT     = 5000;
  // The pipeline is three stages deep; give it a little more before the end.
  localparam int SETTLE_CYCLES   = 10;

  // --------------------------------------------------------------------------
  // Scoreboard. Every accepted HSV request pushes its predicted RGB pixel;
  // every accepted result pops the oldest one and compares it field by field.
  // --------------------------------------------------------------------------
  class rgb_scoreboard;
    pixel_out_t expected_rgb_q[$];
    int         mismatches;
    int         checked;
    int         path_count[color_path_t];

    function new();
      mismatches = 0;
      checked    = 0;
      path_count[PATH_EXACT]   = 0;
      path_count[PATH_GREY]    = 0;
      path_count[PATH_SEXTANT] = 0;
    endfunction

    function logic [7:0] clip_chan(logic [31:0] x);
      return (x > 32'(CHAN_MAX)) ? CHAN_MAX : x[7:0];
    endfunction

    // Fixed-point HSV to RGB, with the exact-color and grey shortcuts first.
    function pixel_out_t predict_rgb(pixel_in_t px, output color_path_t path);
      logic [31:0] val_s, sat, sat_s, hue6, frac;
      logic [31:0] p, q, t, r, g, b;
      logic [7:0]  v;
      sector_t     sect;
      pixel_out_t  rgb;
      v = px.brightness;
      if (px.saturation == CHAN_MAX) begin
        path = PATH_EXACT;
        case (px.hue)
          HUE_RED_LO, HUE_RED_HI: return '{v, 8'h00, 8'h00};
          HUE_YELLOW:             return '{v, v, 8'h00};
          HUE_GREEN:              return '{8'h00, v, 8'h00};
          HUE_CYAN:               return '{8'h00, v, v};
          HUE_BLUE:               return '{8'h00, 8'h00, v};
          HUE_MAGENTA:            return '{v, 8'h00, v};
          default:                path = PATH_SEXTANT;
        endcase
      end
      if (px.saturation == 8'd0) begin
        path = PATH_GREY;
        return '{v, v, v};
      end
      path  = PATH_SEXTANT;
      sat   = 32'(px.saturation);
      val_s = 32'(v) << 8;
      sat_s = sat << 8;
      hue6  = 32'(px.hue) * 32'd6;
      sect  = sector_t'(hue6[10:8]);
      frac  = hue6 & 32'd255;
      p = (val_s * (32'(FULL16) - sat_s)) >> 16;
      q = (val_s * (32'(FULL16) - frac * sat)) >> 16;
      t = (val_s * (32'(FULL16) - (32'd255 - frac) * sat)) >> 16;
      case (sect)
        SECT_RED_YELLOW:   begin r = val_s; g = t;     b = p;     end
        SECT_YELLOW_GREEN: begin r = q;     g = val_s; b = p;     end
        SECT_GREEN_CYAN:   begin r = p;     g = val_s; b = t;     end
        SECT_CYAN_BLUE:    begin r = p;     g = q;     b = val_s; end
        SECT_BLUE_MAGENTA: begin r = t;     g = p;     b = val_s; end
        default:           begin r = val_s; g = p;     b = q;     end
      endcase
      rgb.red   = clip_chan(r >> 8);
      rgb.green = clip_chan(g >> 8);
      rgb.blue  = clip_chan(b >> 8);
      return rgb;
    endfunction

    function void note_request(pixel_in_t px);
      color_path_t path;
      expected_rgb_q.push_back(predict_rgb(px, path));
      path_count[path]++;
    endfunction

    function void report_field(string field, logic [7:0] want, logic [7:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t want;
      if (expected_rgb_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with no pending request, actual %h", $time, got);
        return;
      end
      want = expected_rgb_q.pop_front();
      checked++;
      if (got.red !== want.red)     report_field("red", want.red, got.red);
      if (got.green !== want.green) report_field("green", want.green, got.green);
      if (got.blue !== want.blue)   report_field("blue", want.blue, got.blue);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  pixel_in_t  in_pixel;
  logic       out_valid;
  logic       out_stall;
  pixel_out_t out_pixel;

  rgb_scoreboard sb = new();

  int accepted_count = 0;
  int blocked_cycles = 0;

  hsv_to_rgb_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Handshake monitor. Everything the bench drives changes through
  // nonblocking assignments, and the block's outputs only move after the
  // edge, so the values read here are the ones the block saw at this edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_request(in_pixel);
      accepted_count++;
    end
    if (rst_n && in_valid && in_stall)
      blocked_cycles++;
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_pixel);
  end

  // Offers one request and returns at the edge that accepts it. The caller
  // decides whether valid stays high for the next request or drops for a gap.
  task automatic offer_request(input pixel_in_t px);
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drops valid for a number of cycles; the payload is junk while idle.
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      in_pixel <= '{8'($urandom), 8'($urandom), 8'($urandom)};
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Sends a list of requests in bursts of random length. Some bursts are long
  // and some gaps are zero, so stretches without any idling occur as well.
  task automatic stream_requests(input pixel_in_t reqs[$]);
    int burst_left;
    burst_left = $urandom_range(1, 24);
    foreach (reqs[i]) begin
      offer_request(reqs[i]);
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0)
          idle_gap($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
      end
    end
    idle_gap(1);
  endtask

  // Random pixels, weighted toward the corners of the conversion: the
  // exact-color hues and their neighbors at full saturation, grey, and
  // extreme values. Most still come from the whole field range.
  function automatic pixel_in_t random_pixel();
    pixel_in_t   px;
    logic [7:0]  exact_hues[7];
    int          pick;
    exact_hues = '{HUE_RED_LO, HUE_YELLOW, HUE_GREEN, HUE_CYAN,
                   HUE_BLUE, HUE_MAGENTA, HUE_RED_HI};
    px.hue        = 8'($urandom_range(0, 255));
    px.saturation = 8'($urandom_range(0, 255));
    px.brightness = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      px.saturation = CHAN_MAX;
      px.hue        = exact_hues[$urandom_range(0, 6)];
    end else if (pick < 4) begin
      px.saturation = CHAN_MAX;
      px.hue        = exact_hues[$urandom_range(0, 6)] + 8'($urandom_range(0, 2)) - 8'd1;
    end else if (pick == 4) begin
      px.saturation = 8'd0;
    end else if (pick == 5) begin
      px.brightness = ($urandom_range(0, 1) == 1) ? CHAN_MAX : 8'd0;
      px.saturation = ($urandom_range(0, 1) == 1) ? 8'd254 : 8'd1;
    end
    return px;
  endfunction

  // Receiver. It cycles through stall patterns of random length, and once,
  // after the stream is well under way, holds the output off long enough
  // that all three stages fill and the block has to stall its input.
  initial begin : receiver
    stall_mode_t mode;
    int          phase_len;
    bit          held_off;
    held_off = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n);
    forever begin
      if (!held_off && accepted_count >= 60) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode      = stall_mode_t'($urandom_range(0, 3));
      phase_len = $urandom_range(20, 60);
      for (int c = 0; c < phase_len; c++) begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= (c % 3 == 2);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog. Even with the receiver stalling heavily the whole time, a
  // correct run ends long before this time limit.
  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence: reset, a directed pass over the corner cases, then the
  // random stream, then drain and report.
  initial begin : main_seq
    pixel_in_t directed_q[$];
    pixel_in_t random_q[$];
    int        waited;
    int        leftover;
    in_valid <= 1'b0;
    in_pixel <= '0;
    rst_n    <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n    <= 1'b1;

    // All fields at their extremes.
    directed_q.push_back('{8'd0, 8'd0, 8'd0});
    directed_q.push_back('{8'd255, 8'd255, 8'd255});
    directed_q.push_back('{8'd100, 8'd0, 8'd255});   // grey at full value
    directed_q.push_back('{8'd37, 8'd0, 8'd0});      // grey, black
    directed_q.push_back('{8'd200, 8'd0, 8'd173});   // grey, mid value
    // The seven exact-color hues at full saturation.
    directed_q.push_back('{HUE_RED_LO, CHAN_MAX, 8'd200});
    directed_q.push_back('{HUE_YELLOW, CHAN_MAX, 8'd200});
    directed_q.push_back('{HUE_GREEN, CHAN_MAX, 8'd255});
    directed_q.push_back('{HUE_CYAN, CHAN_MAX, 8'd200});
    directed_q.push_back('{HUE_BLUE, CHAN_MAX, 8'd1});
    directed_q.push_back('{HUE_MAGENTA, CHAN_MAX, 8'd200});
    directed_q.push_back('{HUE_RED_HI, CHAN_MAX, 8'd200});
    // Neighbors of exact hues, and an exact hue just below full saturation,
    // all of which must take the general sextant path.
    directed_q.push_back('{8'd42, CHAN_MAX, 8'd255});
    directed_q.push_back('{8'd44, CHAN_MAX, 8'd255});
    directed_q.push_back('{8'd254, CHAN_MAX, 8'd255});
    directed_q.push_back('{8'd1, CHAN_MAX, 8'd255});
    directed_q.push_back('{HUE_YELLOW, 8'd254, 8'd255});
    // One hue inside each of the six sextants.
    directed_q.push_back('{8'd20, 8'd128, 8'd255});
    directed_q.push_back('{8'd60, 8'd128, 8'd255});
    directed_q.push_back('{8'd100, 8'd128, 8'd255});
    directed_q.push_back('{8'd150, 8'd128, 8'd255});
    directed_q.push_back('{8'd190, 8'd128, 8'd255});
    directed_q.push_back('{8'd230, 8'd128, 8'd255});
    // Smallest saturation and zero value on the general path.
    directed_q.push_back('{8'd77, 8'd1, 8'd255});
    directed_q.push_back('{8'd77, 8'd128, 8'd0});
    stream_requests(directed_q);

    for (int i = 0; i < RANDOM_PIXELS; i++)
      random_q.push_back(random_pixel());
    stream_requests(random_q);
    in_valid <= 1'b0;

    // Wait for every predicted pixel to come out, then let the pipeline settle
    // in case the block produces something it should not.
    waited = 0;
    while (sb.expected_rgb_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    leftover = sb.expected_rgb_q.size();
    if (leftover != 0)
      $display("%0t: %0d expected pixels never came out", $time, leftover);

    $display("Converted %0d pixels: %0d exact colors, %0d grey, %0d through the sextant math.",
             accepted_count, sb.path_count[PATH_EXACT], sb.path_count[PATH_GREY],
             sb.path_count[PATH_SEXTANT]);
    $display("Checked %0d results; input was held off for %0d cycles by backpressure.",
             sb.checked, blocked_cycles);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
